/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/tlbpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, types and control structs of the TLB / page-table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int VA_W        = 16;
  localparam int PAGE_W      = 8;
  localparam int FRAME_W     = 8;
  localparam int OFFSET_W    = 8;
  localparam int TLB_DEPTH   = 16;
  localparam int TLB_IDX_W   = $clog2(TLB_DEPTH);
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_COUNT = 256;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    logic   valid;
    page_t  page;
    frame_t frame;
  } tlb_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // take an address beat, launch table reads
    logic evict_read;   // read the page-table entry of the frame's old owner
    logic commit;       // update state and load the result register
    logic evict_apply;  // commit follows an owner read: drop a stale mapping
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tlb_hit;
    logic map_valid;
    logic wrapped;
    logic out_free;
  } status_t;

endpackage

/* rtl/tlbpt_va_if.sv */
// ----------------------------------------------------------------------------
// tlbpt_va_if
// Virtual-address channel: valid/ready handshake with the address payload.
// ----------------------------------------------------------------------------
interface tlbpt_va_if;
  logic        valid;
  logic        ready;
  logic [15:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

/* rtl/tlbpt_pa_if.sv */
// ----------------------------------------------------------------------------
// tlbpt_pa_if
// Translation result channel: physical address with hit and fault flags.
// ----------------------------------------------------------------------------
interface tlbpt_pa_if;
  logic        valid;
  logic        ready;
  logic [15:0] physical_address;
  logic        tlb_hit;
  logic        page_fault;

  modport source (output valid, output physical_address, output tlb_hit,
                  output page_fault, input ready);
  modport sink (input valid, input physical_address, input tlb_hit,
                input page_fault, output ready);
endinterface

/* rtl/tlbpt_ram.sv */
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next enabled read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tlbpt_ctrl.sv */
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer: accept, look up, optional owner read, commit.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tlbpt_pkg::status_t status,
  output tlbpt_pkg::cmd_t    cmd
);
  import tlbpt_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_EVICT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       need_evict;

  // Fault after the frames have wrapped needs the old owner's entry
  assign need_evict = !status.tlb_hit && !status.map_valid && status.wrapped;
  assign in_ready   = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (need_evict) begin
          cmd.evict_read = 1'b1;
          state_next     = ST_EVICT;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EVICT: begin
        if (status.out_free) begin
          cmd.commit      = 1'b1;
          cmd.evict_apply = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/tlbpt_dpath.sv */
// ----------------------------------------------------------------------------
// tlbpt_dpath
// TLB registers, page-table and frame-owner RAMs, frame FIFO, result register.
// ----------------------------------------------------------------------------
module tlbpt_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  tlbpt_pkg::cmd_t                 cmd,
  output tlbpt_pkg::status_t              status,
  input  logic [tlbpt_pkg::VA_W-1:0]      in_va,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tlbpt_pkg::VA_W-1:0]      out_pa,
  output logic                            out_hit,
  output logic                            out_fault
);
  import tlbpt_pkg::*;

  logic [VA_W-1:0]       va;
  page_t                 page;
  logic [OFFSET_W-1:0]   offset;
  logic [PAGE_COUNT-1:0] map_valid;
  tlb_entry_t            tlb [TLB_DEPTH];
  logic [TLB_IDX_W-1:0]  fill_ptr;
  frame_t                next_frame;
  logic                  wrapped;

  logic                  hit;
  frame_t                hit_frame;
  logic                  match_found;
  logic [TLB_IDX_W-1:0]  match_idx;
  logic [TLB_IDX_W-1:0]  inst_idx;
  frame_t                frame_sel;
  logic                  fault;
  logic                  evict_clear;

  logic                  pt_re;
  logic                  pt_we;
  page_t                 pt_raddr;
  frame_t                pt_rdata;
  page_t                 own_rdata;

  assign page   = va[VA_W-1:OFFSET_W];
  assign offset = va[OFFSET_W-1:0];

  // Search the TLB by page, lowest index wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (tlb[i].valid && tlb[i].page == page) begin
        hit       = 1'b1;
        hit_frame = tlb[i].frame;
      end
    end
  end

  // Pick the translated frame
  assign fault     = !hit && !map_valid[page];
  assign frame_sel = hit ? hit_frame : (map_valid[page] ? pt_rdata : next_frame);

  // Search the TLB by frame for retargeting, lowest index wins
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (tlb[i].valid && tlb[i].frame == frame_sel) begin
        match_found = 1'b1;
        match_idx   = TLB_IDX_W'(i);
      end
    end
  end

  assign inst_idx = match_found ? match_idx : fill_ptr;

  // Drop the old owner's mapping only if it still points at this frame
  assign evict_clear = cmd.evict_apply && (own_rdata != page) &&
                       map_valid[own_rdata] && (pt_rdata == next_frame);

  // Page-table RAM: page lookup at accept, old owner lookup on eviction
  assign pt_re    = cmd.accept || cmd.evict_read;
  assign pt_raddr = cmd.accept ? in_va[VA_W-1:OFFSET_W] : own_rdata;
  assign pt_we    = cmd.commit && fault;

  tlbpt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (PAGE_COUNT)
  ) u_page_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (page),
    .wdata (next_frame),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // Frame-owner RAM: read the owner of the next frame at accept
  tlbpt_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (FRAME_COUNT)
  ) u_owner_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (next_frame),
    .wdata (page),
    .re    (cmd.accept),
    .raddr (next_frame),
    .rdata (own_rdata)
  );

  assign status.tlb_hit   = hit;
  assign status.map_valid = map_valid[page];
  assign status.wrapped   = wrapped;
  assign status.out_free  = !out_valid || out_ready;

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid  <= '0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
        tlb[i].valid <= 1'b0;
      end
      fill_ptr   <= '0;
      next_frame <= '0;
      wrapped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        va <= in_va;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        out_pa    <= {frame_sel, offset};
        out_hit   <= hit;
        out_fault <= fault;
        // Assign the next frame in FIFO order
        if (fault) begin
          if (evict_clear) begin
            map_valid[own_rdata] <= 1'b0;
          end
          map_valid[page] <= 1'b1;
          if (next_frame == FRAME_W'(FRAME_COUNT - 1)) begin
            next_frame <= '0;
            wrapped    <= 1'b1;
          end else begin
            next_frame <= next_frame + 1'b1;
          end
        end
        // Install the translation after any TLB miss
        if (!hit) begin
          tlb[inst_idx] <= '{valid: 1'b1, page: page, frame: frame_sel};
          if (!match_found) begin
            fill_ptr <= (fill_ptr == TLB_IDX_W'(TLB_DEPTH - 1)) ? '0 : fill_ptr + 1'b1;
          end
        end
      end
    end
  end

endmodule

/* rtl/tlb_page_table_translator.sv */
// A 16-bit virtual address is translated one beat at a time: the upper byte is the
// page, the lower byte the offset. Each beat passes through an accept cycle, which
// launches the page-table and frame-owner RAM reads, and a lookup cycle, in which the
// TLB compare and the page-table read data pick the frame. The result is loaded into
// the output register by the commit that ends the lookup. A page fault after all
// frames have been handed out once adds an eviction state before the commit, since the
// page-table entry of the frame's previous owner is read from the same RAM port before
// it may be dropped. A new address is taken in the cycle after the previous one has been
// committed, while its result may still wait in the output register. The commit waits
// while the output register holds a stalled beat, which stretches the item by the
// length of that stall. Page-table valid bits live in flops cleared by reset, so no
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// TLB with page-table fallback and FIFO frame assignment.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
  input logic  clk,
  input logic  rst,
  tlbpt_va_if.sink   addr_ch,
  tlbpt_pa_if.source xlat_ch
);
  import tlbpt_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  tlbpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (addr_ch.valid),
    .in_ready (addr_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Translation datapath
  tlbpt_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_va     (addr_ch.virtual_address),
    .out_ready (xlat_ch.ready),
    .out_valid (xlat_ch.valid),
    .out_pa    (xlat_ch.physical_address),
    .out_hit   (xlat_ch.tlb_hit),
    .out_fault (xlat_ch.page_fault)
  );

endmodule

/* rtl/tlbpt_checker.sv */
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port-level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlbpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pa,
  input logic        out_hit,
  input logic        out_fault
);

  // Hold a stalled result beat
  `ASSERT_PROP(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "result beat dropped")
  `ASSERT_PROP(a_out_stable, clk, rst, (out_valid && !out_ready) |=> $stable(out_pa) && $stable(out_hit) && $stable(out_fault), "stalled result changed")

  // One address at a time: busy the cycle after an accept
  `ASSERT_PROP(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready, "address taken while busy")

  // A result never appears in the cycle right after its address
  `ASSERT_PROP(a_no_early_result, clk, rst, (in_valid && in_ready && !out_valid) |=> !out_valid, "result too early")

  // A TLB hit never assigns a frame
  `ASSERT_NEVER(a_hit_no_fault, clk, rst, out_valid && out_hit && out_fault, "hit and fault together")

endmodule

bind tlb_page_table_translator tlbpt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (addr_ch.valid),
  .in_ready  (addr_ch.ready),
  .out_valid (xlat_ch.valid),
  .out_ready (xlat_ch.ready),
  .out_pa    (xlat_ch.physical_address),
  .out_hit   (xlat_ch.tlb_hit),
  .out_fault (xlat_ch.page_fault)
);

/* dv/tlb_xlat_checker.sv */
// ----------------------------------------------------------------------------
// tlb_xlat_checker
// Watches the address and result channels of the translator, keeps its own
// copy of the TLB, page table and frame pool, and checks every result beat
// against the oldest predicted translation.
// ----------------------------------------------------------------------------
module tlb_xlat_checker (
  input  logic       clk,
  input  logic       rst,
  tlbpt_va_if        addr_ch,
  tlbpt_pa_if        xlat_ch,
  output int         errors,
  output int         pending,
  output int         checked,
  output int         hits,
  output int         faults,
  output logic       pool_wrapped
);

  timeunit 1ns;
  timeprecision 1ps;

  import tlbpt_pkg::*;

  typedef struct packed {
    logic [VA_W-1:0] pa;
    logic            hit;
    logic            fault;
  } xlat_t;

  // Shadow translation state
  logic [FRAME_W:0]     page_map_q [PAGE_COUNT];
  page_t                frame_owner_q [FRAME_COUNT];
  tlb_entry_t           tlb_q [TLB_DEPTH];
  logic [TLB_IDX_W-1:0] fill_ptr;
  frame_t               free_frame;
  logic                 wrapped;

  xlat_t xlat_q [$];
  int    mismatch_n;
  int    checked_n;
  int    hit_n;
  int    fault_n;

  assign errors       = mismatch_n;
  assign checked      = checked_n;
  assign hits         = hit_n;
  assign faults       = fault_n;
  assign pool_wrapped = wrapped;

  task automatic report(input string what);
    $display("[%0t] ERROR: %s", $time, what);
    mismatch_n++;
  endtask

  // Translate one address and update the shadow state the way the block does
  function automatic xlat_t translate(input logic [VA_W-1:0] va);
    page_t  pg;
    frame_t fr;
    page_t  old_pg;
    logic   hit;
    logic   fault;
    logic   placed;
    xlat_t  r;
    pg    = va[VA_W-1 -: PAGE_W];
    fr    = '0;
    hit   = 1'b0;
    fault = 1'b0;
    // Search the TLB; the lowest matching valid entry wins
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (!hit && tlb_q[i].valid && tlb_q[i].page == pg) begin
        fr  = tlb_q[i].frame;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (page_map_q[pg][FRAME_W]) begin
        fr = page_map_q[pg][FRAME_W-1:0];
      end else begin
        // Page fault: take the next frame, drop the previous owner if still mapped
        fault = 1'b1;
        fr    = free_frame;
        if (wrapped) begin
          old_pg = frame_owner_q[fr];
          if (old_pg != pg && page_map_q[old_pg][FRAME_W] &&
              page_map_q[old_pg][FRAME_W-1:0] == fr) begin
            page_map_q[old_pg] = '0;
          end
        end
        page_map_q[pg]    = {1'b1, fr};
        frame_owner_q[fr] = pg;
        free_frame        = fr + 1'b1;
        if (free_frame == '0) wrapped = 1'b1;
      end
      // Retarget an entry already holding the frame, else replace at the pointer
      placed = 1'b0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
        if (!placed && tlb_q[i].valid && tlb_q[i].frame == fr) begin
          tlb_q[i].page = pg;
          placed        = 1'b1;
        end
      end
      if (!placed) begin
        tlb_q[fill_ptr] = {1'b1, pg, fr};
        fill_ptr        = fill_ptr + 1'b1;
      end
    end
    r.pa    = {fr, va[OFFSET_W-1:0]};
    r.hit   = hit;
    r.fault = fault;
    return r;
  endfunction

  // Predict on address beats, compare on result beats
  always @(posedge clk) begin
    xlat_t want;
    if (rst) begin
      for (int i = 0; i < PAGE_COUNT; i++) page_map_q[i] = '0;
      for (int i = 0; i < FRAME_COUNT; i++) frame_owner_q[i] = '0;
      for (int i = 0; i < TLB_DEPTH; i++) tlb_q[i] = '0;
      fill_ptr   = '0;
      free_frame = '0;
      wrapped    = 1'b0;
      xlat_q.delete();
      mismatch_n = 0;
      checked_n  = 0;
      hit_n      = 0;
      fault_n    = 0;
      pending <= 0;
    end else begin
      if (addr_ch.valid && addr_ch.ready) begin
        want = translate(addr_ch.virtual_address);
        xlat_q.push_back(want);
        hit_n   += want.hit;
        fault_n += want.fault;
      end
      if (xlat_ch.valid && xlat_ch.ready) begin
        if (xlat_q.size() == 0) begin
          report($sformatf("result beat pa=%h with no translation pending",
                           xlat_ch.physical_address));
        end else begin
          want = xlat_q.pop_front();
          checked_n++;
          if (xlat_ch.physical_address !== want.pa)
            report($sformatf("physical_address got %h want %h",
                             xlat_ch.physical_address, want.pa));
          if (xlat_ch.tlb_hit !== want.hit)
            report($sformatf("tlb_hit got %b want %b (pa %h)",
                             xlat_ch.tlb_hit, want.hit, want.pa));
          if (xlat_ch.page_fault !== want.fault)
            report($sformatf("page_fault got %b want %b (pa %h)",
                             xlat_ch.page_fault, want.fault, want.pa));
        end
      end
      pending <= xlat_q.size();
    end
  end

endmodule

/* dv/tlb_page_table_translator_tb.sv */
// ----------------------------------------------------------------------------
// tlb_page_table_translator_tb
// Drives virtual addresses into the translator in bursts, stalls the result
// side, and lets the checker judge every translation: directed corner cases,
// then working-set traffic, a sweep of every page, and mixed random traffic.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tlbpt_va_if addr_ch ();
  tlbpt_pa_if xlat_ch ();

  int       errors;
  int       pending;
  int       checked;
  int       hits;
  int       faults;
  logic     pool_wrapped;
  int       burst_left;
  rx_mode_t rx_mode;
  int       rx_left;

  tlb_page_table_translator dut (
    .clk     (clk),
    .rst     (rst),
    .addr_ch (addr_ch),
    .xlat_ch (xlat_ch)
  );

  tlb_xlat_checker chk (
    .clk          (clk),
    .rst          (rst),
    .addr_ch      (addr_ch),
    .xlat_ch      (xlat_ch),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .hits         (hits),
    .faults       (faults),
    .pool_wrapped (pool_wrapped)
  );

  always #4 clk = ~clk;

  // Stall the result side in stretches of one pattern each
  always @(posedge clk) begin
    if (rst) begin
      rx_mode <= RX_STEADY;
      rx_left <= 0;
      xlat_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 80);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_STEADY:   xlat_ch.ready <= 1'b1;
        RX_COIN:     xlat_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   xlat_ch.ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: xlat_ch.ready <= (rx_left[2:0] < 3'd5);
        default:     xlat_ch.ready <= 1'b1;
      endcase
    end
  end

  // Send one address beat; close the burst with an idle gap when it runs out
  task automatic push_addr(input logic [15:0] va);
    addr_ch.valid <= 1'b1;
    addr_ch.virtual_address <= va;
    @(posedge clk);
    while (!addr_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      addr_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 30);
    end
  endtask

  // Hold off the sender until every predicted translation has come back
  task automatic drain();
    addr_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Pick an address inside a small window of pages so the TLB sees reuse
  function automatic logic [15:0] near_addr(input logic [7:0] base);
    logic [7:0] pg;
    pg = base + 8'($urandom_range(0, 23));
    return {pg, 8'($urandom_range(0, 255))};
  endfunction

  initial begin
    logic [7:0] base;
    addr_ch.valid <= 1'b0;
    addr_ch.virtual_address <= '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, repeat hits, TLB overflow, miss with a valid mapping
    push_addr(16'h0000);
    push_addr(16'h0000);
    push_addr(16'hFFFF);
    push_addr(16'hFF00);
    push_addr(16'h00FF);
    push_addr(16'h8055);
    push_addr(16'h7FAA);
    for (int p = 1; p <= 16; p++) push_addr({8'(p), 8'(p * 17)});
    push_addr(16'h0012);
    drain();

    // Working-set traffic with a drifting window
    base = 8'($urandom_range(0, 255));
    for (int n = 0; n < 450; n++) begin
      if (n % 64 == 63) base = 8'($urandom_range(0, 255));
      push_addr(($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                             : near_addr(base));
    end

    // Touch every page so the frame pool wraps
    for (int p = 0; p < 256; p++) push_addr({8'(p), 8'($urandom_range(0, 255))});
    drain();

    // Mixed traffic after the wrap
    for (int n = 0; n < 470; n++) begin
      if (n % 50 == 49) base = 8'($urandom_range(0, 255));
      push_addr(($urandom_range(0, 9) < 3) ? 16'($urandom_range(0, 65535))
                                            : near_addr(base));
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Checked %0d translations: %0d TLB hits, %0d page faults.",
             checked, hits, faults);
    $display("Frame pool wrapped: %s; mismatches: %0d.",
             pool_wrapped ? "yes" : "no", errors);
    if (errors == 0 && pending == 0) begin
      $display("tlb_page_table_translator: match");
    end else begin
      $display("tlb_page_table_translator: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("Timeout with %0d translations still pending.", pending);
    $display("tlb_page_table_translator: mismatch");
    $finish;
  end

endmodule

/* tlb_page_table_translator.f */
+incdir+rtl
rtl/tlbpt_pkg.sv
rtl/tlbpt_va_if.sv
rtl/tlbpt_pa_if.sv
rtl/tlbpt_ram.sv
rtl/tlbpt_ctrl.sv
rtl/tlbpt_dpath.sv
rtl/tlb_page_table_translator.sv
rtl/tlbpt_checker.sv
dv/tlb_xlat_checker.sv
dv/tlb_page_table_translator_tb.sv
